>>> rtl/core/actc_pkg.sv
package actc_pkg;

	typedef struct packed {
		logic [7:0] glyph;
		logic [7:0] fg_index;
		logic [7:0] bg_index;
		logic       frame_start;
		logic       newline_after;
	} cell_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} term_t;

	localparam int GLYPH_DEPTH = 256;
	localparam int CODE_W      = 16;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_4    = 8'h34;
	localparam logic [7:0] CH_5    = 8'h35;
	localparam logic [7:0] CH_8    = 8'h38;

	// CP437 code points, zero and 255 both map to a space.
	localparam logic [15:0] GLYPH_CODE [GLYPH_DEPTH] = '{
		16'h0020,16'h263A,16'h263B,16'h2665,16'h2666,16'h2663,16'h2660,16'h2022,
		16'h25D8,16'h25CB,16'h25D9,16'h2642,16'h2640,16'h266A,16'h266B,16'h263C,
		16'h25BA,16'h25C4,16'h2195,16'h203C,16'h00B6,16'h00A7,16'h25AC,16'h21A8,
		16'h2191,16'h2193,16'h2192,16'h2190,16'h221F,16'h2194,16'h25B2,16'h25BC,
		16'h0020,16'h0021,16'h0022,16'h0023,16'h0024,16'h0025,16'h0026,16'h0027,
		16'h0028,16'h0029,16'h002A,16'h002B,16'h002C,16'h002D,16'h002E,16'h002F,
		16'h0030,16'h0031,16'h0032,16'h0033,16'h0034,16'h0035,16'h0036,16'h0037,
		16'h0038,16'h0039,16'h003A,16'h003B,16'h003C,16'h003D,16'h003E,16'h003F,
		16'h0040,16'h0041,16'h0042,16'h0043,16'h0044,16'h0045,16'h0046,16'h0047,
		16'h0048,16'h0049,16'h004A,16'h004B,16'h004C,16'h004D,16'h004E,16'h004F,
		16'h0050,16'h0051,16'h0052,16'h0053,16'h0054,16'h0055,16'h0056,16'h0057,
		16'h0058,16'h0059,16'h005A,16'h005B,16'h005C,16'h005D,16'h005E,16'h005F,
		16'h0060,16'h0061,16'h0062,16'h0063,16'h0064,16'h0065,16'h0066,16'h0067,
		16'h0068,16'h0069,16'h006A,16'h006B,16'h006C,16'h006D,16'h006E,16'h006F,
		16'h0070,16'h0071,16'h0072,16'h0073,16'h0074,16'h0075,16'h0076,16'h0077,
		16'h0078,16'h0079,16'h007A,16'h007B,16'h007C,16'h007D,16'h007E,16'h2302,
		16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E4,16'h00E0,16'h00E5,16'h00E7,
		16'h00EA,16'h00EB,16'h00E8,16'h00EF,16'h00EE,16'h00EC,16'h00C4,16'h00C5,
		16'h00C9,16'h00E6,16'h00C6,16'h00F4,16'h00F6,16'h00F2,16'h00FB,16'h00F9,
		16'h00FF,16'h00D6,16'h00DC,16'h00A2,16'h00A3,16'h00A5,16'h20A7,16'h0192,
		16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h00F1,16'h00D1,16'h00AA,16'h00BA,
		16'h00BF,16'h2310,16'h00AC,16'h00BD,16'h00BC,16'h00A1,16'h00AB,16'h00BB,
		16'h2591,16'h2592,16'h2593,16'h2502,16'h2524,16'h2561,16'h2562,16'h2556,
		16'h2555,16'h2563,16'h2551,16'h2557,16'h255D,16'h255C,16'h255B,16'h2510,
		16'h2514,16'h2534,16'h252C,16'h251C,16'h2500,16'h253C,16'h255E,16'h255F,
		16'h255A,16'h2554,16'h2569,16'h2566,16'h2560,16'h2550,16'h256C,16'h2567,
		16'h2568,16'h2564,16'h2565,16'h2559,16'h2558,16'h2552,16'h2553,16'h256B,
		16'h256A,16'h2518,16'h250C,16'h2588,16'h2584,16'h258C,16'h2590,16'h2580,
		16'h03B1,16'h00DF,16'h0393,16'h03C0,16'h03A3,16'h03C3,16'h00B5,16'h03C4,
		16'h03A6,16'h0398,16'h03A9,16'h03B4,16'h221E,16'h03C6,16'h03B5,16'h2229,
		16'h2261,16'h00B1,16'h2265,16'h2264,16'h2320,16'h2321,16'h00F7,16'h2248,
		16'h00B0,16'h2219,16'h00B7,16'h221A,16'h207F,16'h00B2,16'h25A0,16'h0020
	};

endpackage

>>> rtl/core/actc_ram.sv
module actc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/actc_seq.sv
module actc_seq import actc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        enable,
	input  logic        cell_valid,
	output logic        cell_ready,
	input  cell_t       cell_req,
	input  logic [15:0] code,
	output logic        push_valid,
	input  logic        push_ready,
	output term_t       push
);

	typedef enum logic [3:0] {
		S_IDLE, S_HOME, S_CSI, S_PRE, S_DEC, S_SEMI, S_M, S_UTF, S_LF
	} state_t;

	state_t      state_q;
	logic [2:0]  pos_q;
	logic [1:0]  comp_q;
	logic        which_q;
	logic        fg_new_q;
	logic        bg_new_q;
	logic        nl_q;
	logic [8:0]  fg_lv_q;
	logic [8:0]  bg_lv_q;
	logic [7:0]  last_fg_q;
	logic [7:0]  last_bg_q;
	logic        known_q;

	// Splits a palette index into three cube levels {r, g, b}, each 0..5.
	function automatic logic [8:0] cube_levels(input logic [7:0] idx);
		logic [7:0]  v;
		logic [13:0] p1;
		logic [2:0]  r;
		logic [5:0]  rem;
		logic [10:0] p2;
		logic [2:0]  g;
		logic [5:0]  b;
		v   = idx - 8'd16;
		p1  = {6'd0, v} * 14'd57;
		r   = p1[13:11];
		rem = 6'(v - 8'(r) * 8'd36);
		p2  = {5'd0, rem} * 11'd43;
		g   = p2[10:8];
		b   = rem - 6'(g * 6'd6);
		if (idx < 8'd16 || idx > 8'd231) begin
			cube_levels = '0;
		end else begin
			cube_levels = {r, g, b[2:0]};
		end
	endfunction

	function automatic logic [2:0] dec_len(input logic [2:0] lv);
		case (lv)
			3'd0:    dec_len = 3'd1;
			3'd1:    dec_len = 3'd2;
			default: dec_len = 3'd3;
		endcase
	endfunction

	// Decimal digits of 51 * level, most significant first.
	function automatic logic [7:0] dec_char(input logic [2:0] lv, input logic [2:0] pos);
		dec_char = CH_0;
		case (lv)
			3'd1:    dec_char = (pos == 3'd0) ? CH_5 : CH_1;
			3'd2:    dec_char = (pos == 3'd0) ? CH_1 : (pos == 3'd1) ? CH_0 : CH_2;
			3'd3:    dec_char = (pos == 3'd0) ? CH_1 : (pos == 3'd1) ? CH_5 : CH_3;
			3'd4:    dec_char = (pos == 3'd0) ? CH_2 : (pos == 3'd1) ? CH_0 : CH_4;
			3'd5:    dec_char = (pos == 3'd0) ? CH_2 : CH_5;
			default: dec_char = CH_0;
		endcase
	endfunction

	function automatic logic [2:0] utf_len(input logic [15:0] cp);
		if (cp < 16'h0080) begin
			utf_len = 3'd1;
		end else if (cp < 16'h0800) begin
			utf_len = 3'd2;
		end else begin
			utf_len = 3'd3;
		end
	endfunction

	function automatic logic [7:0] utf_byte(input logic [15:0] cp, input logic [2:0] pos);
		logic [2:0] len;
		len = utf_len(cp);
		utf_byte = 8'h80 | {2'b00, cp[5:0]};
		case (pos)
			3'd0: begin
				if (len == 3'd1) begin
					utf_byte = cp[7:0];
				end else if (len == 3'd2) begin
					utf_byte = 8'hC0 | {3'b000, cp[10:6]};
				end else begin
					utf_byte = 8'hE0 | {4'b0000, cp[15:12]};
				end
			end
			3'd1: begin
				if (len == 3'd3) begin
					utf_byte = 8'h80 | {2'b00, cp[11:6]};
				end
			end
			default: utf_byte = 8'h80 | {2'b00, cp[5:0]};
		endcase
	endfunction

	logic [8:0] lv_set;
	logic [2:0] lv;
	logic [7:0] cur_byte;
	logic       seg_end;
	logic       is_last;
	logic       adv;
	logic       take;
	logic       fg_new_in;
	logic       bg_new_in;

	always_comb begin
		lv_set = which_q ? bg_lv_q : fg_lv_q;
		case (comp_q)
			2'd0:    lv = lv_set[8:6];
			2'd1:    lv = lv_set[5:3];
			default: lv = lv_set[2:0];
		endcase
	end

	always_comb begin
		cur_byte = CH_SEMI;
		seg_end  = 1'b1;
		case (state_q)
			S_HOME: begin
				cur_byte = (pos_q == 3'd0) ? CH_ESC : (pos_q == 3'd1) ? CH_LBR : CH_H;
				seg_end  = (pos_q == 3'd2);
			end
			S_CSI: begin
				cur_byte = (pos_q == 3'd0) ? CH_ESC : CH_LBR;
				seg_end  = (pos_q == 3'd1);
			end
			S_PRE: begin
				case (pos_q)
					3'd0:    cur_byte = which_q ? CH_4 : CH_3;
					3'd1:    cur_byte = CH_8;
					3'd3:    cur_byte = CH_2;
					default: cur_byte = CH_SEMI;
				endcase
				seg_end = (pos_q == 3'd4);
			end
			S_DEC: begin
				cur_byte = dec_char(lv, pos_q);
				seg_end  = (pos_q == dec_len(lv) - 3'd1);
			end
			S_SEMI:  cur_byte = CH_SEMI;
			S_M:     cur_byte = CH_M;
			S_UTF: begin
				cur_byte = utf_byte(code, pos_q);
				seg_end  = (pos_q == utf_len(code) - 3'd1);
			end
			S_LF:    cur_byte = CH_LF;
			default: cur_byte = CH_SEMI;
		endcase
	end

	assign is_last    = (state_q == S_LF) || (state_q == S_UTF && seg_end && !nl_q);
	assign push_valid = (state_q != S_IDLE);
	assign push       = '{out_byte: cur_byte, last_byte: is_last};
	assign adv        = push_valid && push_ready;
	assign cell_ready = enable && (state_q == S_IDLE || (adv && is_last));
	assign take       = cell_valid && cell_ready;

	assign fg_new_in = cell_req.frame_start || !known_q || (cell_req.fg_index != last_fg_q);
	assign bg_new_in = cell_req.frame_start || !known_q || (cell_req.bg_index != last_bg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			comp_q    <= '0;
			which_q   <= 1'b0;
			fg_new_q  <= 1'b0;
			bg_new_q  <= 1'b0;
			nl_q      <= 1'b0;
			last_fg_q <= '0;
			last_bg_q <= '0;
			known_q   <= 1'b0;
		end else if (take) begin
			pos_q     <= '0;
			comp_q    <= '0;
			which_q   <= !fg_new_in;
			fg_new_q  <= fg_new_in;
			bg_new_q  <= bg_new_in;
			nl_q      <= cell_req.newline_after;
			last_fg_q <= cell_req.fg_index;
			last_bg_q <= cell_req.bg_index;
			known_q   <= 1'b1;
			if (cell_req.frame_start) begin
				state_q <= S_HOME;
			end else if (fg_new_in || bg_new_in) begin
				state_q <= S_CSI;
			end else begin
				state_q <= S_UTF;
			end
		end else if (adv) begin
			if (!seg_end) begin
				pos_q <= pos_q + 3'd1;
			end else begin
				pos_q <= '0;
				case (state_q)
					S_HOME:  state_q <= (fg_new_q || bg_new_q) ? S_CSI : S_UTF;
					S_CSI:   state_q <= S_PRE;
					S_PRE: begin
						state_q <= S_DEC;
						comp_q  <= '0;
					end
					S_DEC: begin
						if (comp_q != 2'd2 || (!which_q && bg_new_q)) begin
							state_q <= S_SEMI;
						end else begin
							state_q <= S_M;
						end
					end
					S_SEMI: begin
						if (comp_q != 2'd2) begin
							state_q <= S_DEC;
							comp_q  <= comp_q + 2'd1;
						end else begin
							state_q <= S_PRE;
							which_q <= 1'b1;
							comp_q  <= '0;
						end
					end
					S_M:     state_q <= S_UTF;
					S_UTF:   state_q <= nl_q ? S_LF : S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// Cube levels are payload, loaded with each cell.
	always_ff @(posedge clk) begin
		if (take) begin
			fg_lv_q <= cube_levels(cell_req.fg_index);
			bg_lv_q <= cube_levels(cell_req.bg_index);
		end
	end

endmodule

>>> rtl/core/actc_outbuf.sv
module actc_outbuf import actc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  term_t push,
	output logic  term_valid,
	input  logic  term_ready,
	output term_t term
);

	term_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign term_valid = (cnt_q != 2'd0);
	assign term       = ent_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = term_valid && term_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push;
		end
	end

endmodule

>>> rtl/core/ansi_truecolor_cell_encoder.sv
// Channel  Direction  Handshake                Payload
// cell     in         cell_valid / cell_ready  cell_t: glyph, colors, frame and line flags
// term     out        term_valid / term_ready  term_t: one stream byte, last-byte mark
//
// A cell produces from 1 byte (glyph only) to 43 bytes (cursor home, both color escapes,
// three UTF-8 bytes and a line feed); the byte sequencer emits one byte a cycle while
// the output buffer has room. The next cell is taken in the cycle in which the sequencer
// passes on the last byte. After reset the glyph table memory is filled from the code
// point table, one entry a cycle, and cell_ready stays low until every entry is written.
// A stall on term holds the sequencer once the two-entry output buffer is full.
module ansi_truecolor_cell_encoder import actc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cell_valid,
	output logic  cell_ready,
	input  cell_t cell_req,
	output logic  term_valid,
	input  logic  term_ready,
	output term_t term
);

	localparam int AW = $clog2(GLYPH_DEPTH);

	// The fill counter walks every table entry once; its top bit marks the end.
	logic [AW:0]       fill_q;
	logic              fill_done;
	logic [CODE_W-1:0] code;
	logic              take;
	logic              push_valid;
	logic              push_ready;
	term_t             push;

	assign fill_done = fill_q[AW];
	assign take      = cell_valid && cell_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!fill_done) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// The code point of a cell's glyph is read when the cell is taken and is held
	// for the whole cell; the glyph bytes come no earlier than the cycle after the take.
	actc_ram #(
		.WIDTH (CODE_W),
		.DEPTH (GLYPH_DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (!fill_done),
		.waddr (fill_q[AW-1:0]),
		.wdata (GLYPH_CODE[fill_q[AW-1:0]]),
		.re    (take),
		.raddr (cell_req.glyph),
		.rdata (code)
	);

	// Color memory and escape sequencing live in the sequencer.
	actc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (fill_done),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_req   (cell_req),
		.code       (code),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push)
	);

	// The output buffer lets the sequencer run on while a byte waits to be taken.
	actc_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push       (push),
		.term_valid (term_valid),
		.term_ready (term_ready),
		.term       (term)
	);

endmodule

>>> rtl/core/actc_checker.sv
module actc_checker import actc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cell_valid,
	input logic  cell_ready,
	input cell_t cell_req,
	input logic  term_valid,
	input logic  term_ready,
	input term_t term
);

	// Cells taken whose last byte has not yet been delivered.
	logic [2:0] open_q;
	logic       cell_take;
	logic       last_take;

	assign cell_take = cell_valid && cell_ready;
	assign last_take = term_valid && term_ready && term.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + {2'b00, cell_take} - {2'b00, last_take};
		end
	end

	a_term_hold: assert property (@(posedge clk) disable iff (!arst_n)
		term_valid && !term_ready |=> term_valid && $stable(term))
		else $error("term request dropped or changed while stalled");

	a_no_stray_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_take |-> open_q != 3'd0)
		else $error("last byte delivered with no cell outstanding");

	a_bounded_open: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd3)
		else $error("too many cells outstanding");

	a_last_not_esc: assert property (@(posedge clk) disable iff (!arst_n)
		last_take |-> term.out_byte != CH_ESC)
		else $error("cell ended on an escape byte");

endmodule

bind ansi_truecolor_cell_encoder actc_checker u_actc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_valid (cell_valid),
	.cell_ready (cell_ready),
	.cell_req   (cell_req),
	.term_valid (term_valid),
	.term_ready (term_ready),
	.term       (term)
);

>>> dv/ansi_truecolor_cell_encoder_tb.sv
`timescale 1ns / 100ps

// Testbench for the truecolor ANSI cell encoder.
//
// Every cell request that is driven is also run through a local predictor. The
// predictor tracks the last foreground and background index and whether any color
// has been sent. It expands the cell into the bytes the terminal should see, and
// queues them with the last-byte mark on the final one. A checker process pops one
// expectation for every byte accepted on the term channel and compares it field by
// field. The sender and the receiver each draw a random wait per item. The random
// part is built from well-formed frames: the first cell carries frame_start, and
// row ends carry newline_after except on the bottom row. Colors mostly repeat, so
// that the "no escape" path is exercised. A share of pure noise cells is mixed in.
module ansi_truecolor_cell_encoder_tb;
	import actc_pkg::*;

	// The longest correct quiet stretch is the table fill after reset. A sender gap or a
	// receiver stall is drawn no longer than tx_gap_max or rx_stall_max. This limit leaves a
	// wide margin over both.
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PAUSE_CYCLES  = 8;

	localparam logic [7:0] ASCII_ESC   = 8'h1B;
	localparam logic [7:0] ASCII_LBR   = 8'h5B;
	localparam logic [7:0] ASCII_H     = 8'h48;
	localparam logic [7:0] ASCII_M     = 8'h6D;
	localparam logic [7:0] ASCII_SEMI  = 8'h3B;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_TWO   = 8'h32;
	localparam logic [7:0] ASCII_THREE = 8'h33;
	localparam logic [7:0] ASCII_FOUR  = 8'h34;
	localparam logic [7:0] ASCII_EIGHT = 8'h38;

	// CP437 glyphs 0x00-0x1F. The printable range 0x20-0x7E maps to itself.
	localparam logic [15:0] CP437_LOW [32] = '{
		16'h0020,16'h263A,16'h263B,16'h2665,16'h2666,16'h2663,16'h2660,16'h2022,
		16'h25D8,16'h25CB,16'h25D9,16'h2642,16'h2640,16'h266A,16'h266B,16'h263C,
		16'h25BA,16'h25C4,16'h2195,16'h203C,16'h00B6,16'h00A7,16'h25AC,16'h21A8,
		16'h2191,16'h2193,16'h2192,16'h2190,16'h221F,16'h2194,16'h25B2,16'h25BC
	};
	localparam logic [15:0] CP437_HOUSE = 16'h2302;
	// CP437 glyphs 0x80-0xFF; the last one is the non-breaking space, sent as a space.
	localparam logic [15:0] CP437_HIGH [128] = '{
		16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E4,16'h00E0,16'h00E5,16'h00E7,
		16'h00EA,16'h00EB,16'h00E8,16'h00EF,16'h00EE,16'h00EC,16'h00C4,16'h00C5,
		16'h00C9,16'h00E6,16'h00C6,16'h00F4,16'h00F6,16'h00F2,16'h00FB,16'h00F9,
		16'h00FF,16'h00D6,16'h00DC,16'h00A2,16'h00A3,16'h00A5,16'h20A7,16'h0192,
		16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h00F1,16'h00D1,16'h00AA,16'h00BA,
		16'h00BF,16'h2310,16'h00AC,16'h00BD,16'h00BC,16'h00A1,16'h00AB,16'h00BB,
		16'h2591,16'h2592,16'h2593,16'h2502,16'h2524,16'h2561,16'h2562,16'h2556,
		16'h2555,16'h2563,16'h2551,16'h2557,16'h255D,16'h255C,16'h255B,16'h2510,
		16'h2514,16'h2534,16'h252C,16'h251C,16'h2500,16'h253C,16'h255E,16'h255F,
		16'h255A,16'h2554,16'h2569,16'h2566,16'h2560,16'h2550,16'h256C,16'h2567,
		16'h2568,16'h2564,16'h2565,16'h2559,16'h2558,16'h2552,16'h2553,16'h256B,
		16'h256A,16'h2518,16'h250C,16'h2588,16'h2584,16'h258C,16'h2590,16'h2580,
		16'h03B1,16'h00DF,16'h0393,16'h03C0,16'h03A3,16'h03C3,16'h00B5,16'h03C4,
		16'h03A6,16'h0398,16'h03A9,16'h03B4,16'h221E,16'h03C6,16'h03B5,16'h2229,
		16'h2261,16'h00B1,16'h2265,16'h2264,16'h2320,16'h2321,16'h00F7,16'h2248,
		16'h00B0,16'h2219,16'h00B7,16'h221A,16'h207F,16'h00B2,16'h25A0,16'h0020
	};

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  cell_valid = 1'b0;
	logic  cell_ready;
	cell_t cell_req   = '0;
	logic  term_valid;
	logic  term_ready = 1'b0;
	term_t term_out;

	// Bytes still owed by the block, oldest first, and the bytes of the cell that
	// is being expanded right now.
	term_t      term_expected[$];
	logic [7:0] cell_bytes[$];

	// The predictor's copy of the color memory.
	logic [7:0] sent_fg      = '0;
	logic [7:0] sent_bg      = '0;
	logic       colors_valid = 1'b0;

	int error_count  = 0;
	int quiet_cycles = 0;
	int tx_gap_max   = 0;
	int rx_stall_max = 0;
	int rx_wait      = 0;

	// The ports are connected by position, in the order of the port list.
	ansi_truecolor_cell_encoder dut (
		clk, arst_n, cell_valid, cell_ready, cell_req, term_valid, term_ready, term_out
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Writes a decimal with no leading zeros.
	function automatic void put_decimal(input int unsigned v);
		if (v >= 100) cell_bytes.push_back(ASCII_ZERO + 8'(v / 100));
		if (v >= 10)  cell_bytes.push_back(ASCII_ZERO + 8'((v / 10) % 10));
		cell_bytes.push_back(ASCII_ZERO + 8'(v % 10));
	endfunction

	// Writes "r;g;b" for one palette index. Only the 6x6x6 cube has a color;
	// the sixteen system entries and the gray ramp come out black.
	function automatic void put_palette_rgb(input logic [7:0] idx);
		int unsigned cube, red, green, blue;
		red = 0;
		green = 0;
		blue = 0;
		if (idx >= 16 && idx <= 231) begin
			cube  = idx - 16;
			red   = (cube / 36) * 51;
			green = ((cube / 6) % 6) * 51;
			blue  = (cube % 6) * 51;
		end
		put_decimal(red);
		cell_bytes.push_back(ASCII_SEMI);
		put_decimal(green);
		cell_bytes.push_back(ASCII_SEMI);
		put_decimal(blue);
	endfunction

	// Expands one cell request into the bytes it must produce and queues them.
	function automatic void expand_cell(input cell_t c);
		logic        fg_changed, bg_changed;
		logic [15:0] code;
		term_t       entry;
		cell_bytes.delete();

		// A new frame homes the cursor and forgets the colors on the screen.
		if (c.frame_start) begin
			cell_bytes.push_back(ASCII_ESC);
			cell_bytes.push_back(ASCII_LBR);
			cell_bytes.push_back(ASCII_H);
			colors_valid = 1'b0;
		end

		// Colors are compared by index, so two different black entries still
		// count as a change.
		fg_changed = !colors_valid || c.fg_index != sent_fg;
		bg_changed = !colors_valid || c.bg_index != sent_bg;
		if (fg_changed || bg_changed) begin
			cell_bytes.push_back(ASCII_ESC);
			cell_bytes.push_back(ASCII_LBR);
			if (fg_changed) begin
				cell_bytes.push_back(ASCII_THREE);
				cell_bytes.push_back(ASCII_EIGHT);
				cell_bytes.push_back(ASCII_SEMI);
				cell_bytes.push_back(ASCII_TWO);
				cell_bytes.push_back(ASCII_SEMI);
				put_palette_rgb(c.fg_index);
				if (bg_changed) cell_bytes.push_back(ASCII_SEMI);
			end
			if (bg_changed) begin
				cell_bytes.push_back(ASCII_FOUR);
				cell_bytes.push_back(ASCII_EIGHT);
				cell_bytes.push_back(ASCII_SEMI);
				cell_bytes.push_back(ASCII_TWO);
				cell_bytes.push_back(ASCII_SEMI);
				put_palette_rgb(c.bg_index);
			end
			cell_bytes.push_back(ASCII_M);
		end

		// Code point of the glyph, then its UTF-8 form.
		if (c.glyph < 8'h20)
			code = CP437_LOW[c.glyph];
		else if (c.glyph == 8'h7F)
			code = CP437_HOUSE;
		else if (c.glyph >= 8'h80)
			code = CP437_HIGH[c.glyph - 8'h80];
		else
			code = {8'h00, c.glyph};

		if (code < 16'h0080) begin
			cell_bytes.push_back(code[7:0]);
		end else if (code < 16'h0800) begin
			cell_bytes.push_back({3'b110, code[10:6]});
			cell_bytes.push_back({2'b10, code[5:0]});
		end else begin
			cell_bytes.push_back({4'b1110, code[15:12]});
			cell_bytes.push_back({2'b10, code[11:6]});
			cell_bytes.push_back({2'b10, code[5:0]});
		end

		if (c.newline_after) cell_bytes.push_back(ASCII_LF);

		sent_fg      = c.fg_index;
		sent_bg      = c.bg_index;
		colors_valid = 1'b1;

		for (int i = 0; i < cell_bytes.size(); i++) begin
			entry.out_byte  = cell_bytes[i];
			entry.last_byte = (i == cell_bytes.size() - 1);
			term_expected.push_back(entry);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	function automatic cell_t mk_cell(input logic [7:0] glyph, input logic [7:0] fg,
			input logic [7:0] bg, input logic frame, input logic nl);
		cell_t c;
		c.glyph         = glyph;
		c.fg_index      = fg;
		c.bg_index      = bg;
		c.frame_start   = frame;
		c.newline_after = nl;
		return c;
	endfunction

	// Sends one request. It is called at a rising edge and returns at the edge
	// where the request is taken. Valid stays high into the next request when
	// there is no gap, so valid is never dropped and raised in the same step.
	task automatic send_cell(input cell_t c);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_req   <= c;
		cell_valid <= 1'b1;
		expand_cell(c);
		do @(posedge clk); while (!cell_ready);
	endtask

	// Stops sending until the block has delivered every byte owed, then pauses.
	task automatic drain_stream();
		cell_valid <= 1'b0;
		while (term_expected.size() != 0) @(posedge clk);
		repeat (PAUSE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Response side: checking, receiver stalls, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin : check_stream
		term_t due;
		if (term_valid && term_ready) begin
			if (term_expected.size() == 0) begin
				error_count++;
				$display("%0t: byte with none expected: expected none, got %h last %b",
					$time, term_out.out_byte, term_out.last_byte);
			end else begin
				due = term_expected.pop_front();
				if (term_out.out_byte !== due.out_byte) begin
					error_count++;
					$display("%0t: out_byte mismatch: expected %h, got %h",
						$time, due.out_byte, term_out.out_byte);
				end
				if (term_out.last_byte !== due.last_byte) begin
					error_count++;
					$display("%0t: last_byte mismatch: expected %b, got %b",
						$time, due.last_byte, term_out.last_byte);
				end
			end
			rx_wait = $urandom_range(0, rx_stall_max);
		end
		// The receiver holds ready low for the drawn number of cycles after each byte.
		if (rx_wait > 0) begin
			term_ready <= 1'b0;
			rx_wait--;
		end else begin
			term_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((cell_valid && cell_ready) || (term_valid && term_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Right after reset no color is known, so even index 0 on both sides gets
	// the combined escape. The same colors again give the glyph alone.
	task automatic test_first_cell();
		send_cell(mk_cell(8'h00, 8'd0, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'h41, 8'd0, 8'd0, 1'b0, 1'b0));
	endtask

	// Palette corners, one-sided escapes, and a change between two black indices.
	task automatic test_palette();
		send_cell(mk_cell(8'h41, 8'd16,  8'd231, 1'b0, 1'b0));
		send_cell(mk_cell(8'h42, 8'd21,  8'd231, 1'b0, 1'b0));
		send_cell(mk_cell(8'h43, 8'd21,  8'd52,  1'b0, 1'b0));
		send_cell(mk_cell(8'h44, 8'd100, 8'd255, 1'b0, 1'b0));
		send_cell(mk_cell(8'h45, 8'd15,  8'd255, 1'b0, 1'b0));
		send_cell(mk_cell(8'h46, 8'd232, 8'd0,   1'b0, 1'b0));
	endtask

	// One, two and three byte glyphs, the house glyph and the glyph that maps to a
	// space; the colors stay put, so only the glyph bytes come out.
	task automatic test_glyphs();
		send_cell(mk_cell(8'h7F, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'hFF, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'h80, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'h01, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'hE0, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'hFE, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'h7E, 8'd232, 8'd0, 1'b0, 1'b0));
		send_cell(mk_cell(8'h14, 8'd232, 8'd0, 1'b0, 1'b0));
	endtask

	// Frame start with unchanged colors still resends both. The third request is
	// the longest cell: home, two white escapes, a three byte glyph and a line feed.
	task automatic test_frame_and_newline();
		send_cell(mk_cell(8'h41, 8'd232, 8'd0,   1'b1, 1'b0));
		send_cell(mk_cell(8'h42, 8'd232, 8'd0,   1'b0, 1'b1));
		send_cell(mk_cell(8'h01, 8'd231, 8'd231, 1'b1, 1'b1));
		send_cell(mk_cell(8'hFF, 8'd255, 8'd255, 1'b1, 1'b1));
	endtask

	// Random screens: frames of a few rows, with colors that mostly carry over
	// from cell to cell. About one cell in ten is pure noise, and now and then
	// the sender waits for the output to drain completely.
	task automatic test_random_frames(input int count, input int gap_max, input int stall_max);
		int         sent, width, height;
		logic [7:0] fg, bg;
		cell_t      c;
		tx_gap_max   = gap_max;
		rx_stall_max = stall_max;
		sent = 0;
		fg = 8'($urandom);
		bg = 8'($urandom);
		while (sent < count) begin
			width  = $urandom_range(1, 8);
			height = $urandom_range(1, 4);
			for (int row = 0; row < height && sent < count; row++) begin
				for (int col = 0; col < width && sent < count; col++) begin
					case ($urandom_range(0, 9))
						0:       fg = 8'($urandom);
						1:       bg = 8'($urandom);
						2: begin
							fg = 8'($urandom);
							bg = 8'($urandom);
						end
						default: ;
					endcase
					if ($urandom_range(0, 9) == 0)
						c = cell_t'($urandom);
					else
						c = mk_cell(8'($urandom), fg, bg, row == 0 && col == 0,
							col == width - 1 && row != height - 1);
					send_cell(c);
					sent++;
					if ($urandom_range(0, 39) == 0) drain_stream();
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		tx_gap_max   = 13;
		rx_stall_max = 13;
		test_first_cell();
		test_palette();
		test_glyphs();
		test_frame_and_newline();

		// Random phases: both sides idling, neither idling, one side at a time.
		test_random_frames(100, 13, 13);
		drain_stream();
		test_random_frames(80, 0, 0);
		test_random_frames(80, 13, 0);
		test_random_frames(80, 0, 13);
		drain_stream();
		test_random_frames(50, 13, 13);

		cell_valid <= 1'b0;
		while (term_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/actc_pkg.sv
rtl/core/actc_ram.sv
rtl/core/actc_seq.sv
rtl/core/actc_outbuf.sv
rtl/core/ansi_truecolor_cell_encoder.sv
rtl/core/actc_checker.sv
dv/ansi_truecolor_cell_encoder_tb.sv
